// ===== rtl/prrs_pkg.sv =====
`timescale 1ns / 1ps

package prrs_pkg;

    localparam logic [2:0] ACT_FORK   = 3'd0;
    localparam logic [2:0] ACT_WAIT   = 3'd1;
    localparam logic [2:0] ACT_SIGNAL = 3'd2;
    localparam logic [2:0] ACT_TICK   = 3'd3;
    localparam logic [2:0] ACT_FINISH = 3'd4;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_ARG = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;
    localparam logic [1:0] STATUS_NO_RUN  = 2'd3;

    localparam logic [1:0] PLACE_FREE  = 2'd0;
    localparam logic [1:0] PLACE_READY = 2'd1;
    localparam logic [1:0] PLACE_WAIT  = 2'd2;
    localparam logic [1:0] PLACE_RUN   = 2'd3;

    localparam logic CFG_TIME_QUANTUM    = 1'b0;
    localparam logic CFG_IO_DEVICE_COUNT = 1'b1;

    localparam int PRIO_W    = 3;
    localparam int ELAPSED_W = 16;
    localparam int DEVICE_W  = 8;
    localparam int STAMP_W   = 16;
    localparam int DEVCNT_W  = 9;
    localparam int CFG_W     = 16;

    typedef struct packed {
        logic [PRIO_W-1:0]    prio;
        logic [ELAPSED_W-1:0] elapsed;
        logic [DEVICE_W-1:0]  device;
        logic [STAMP_W-1:0]   stamp;
        logic [1:0]           place;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WR_CUR,
        S_WR_NEW,
        S_SCAN,
        S_SCAN_END,
        S_SIG_WR,
        S_WR_HEAD,
        S_DONE
    } sched_state_t;

endpackage

// ===== rtl/prrs_ram.sv =====
`timescale 1ns / 1ps

module prrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/priority_round_robin_scheduler_core.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// in        sink       in_valid / in_stall action, priority_req, io_device
// out       source     out_valid/out_stall status, new_thread_id, running_valid,
//                                          running_thread, switched, signaled_count
// cfg       sink       cfg_we              cfg_index, cfg_wdata
//
// One beat at a time. Wait, finish and tick make one pass over the thread memory,
// one entry per cycle, over every id given so far; a fork or a rejected beat makes none.
// Signal makes one such pass per waiter that it wakes, and one more that finds none.
// Reset needs no clearing pass: ids at or above the id counter read as free.
// in_stall is high while a beat is at work; a stalled result holds the last cycle.

module priority_round_robin_scheduler_core #(
    parameter int MAX_THREADS  = 64,
    parameter int MAX_DEVICES  = 256,
    parameter int MAX_PRIORITY = 5
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [2:0]                             action,
    input  logic [prrs_pkg::PRIO_W-1:0]            priority_req,
    input  logic [prrs_pkg::DEVICE_W-1:0]          io_device,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [1:0]                             status,
    output logic [$clog2(MAX_THREADS)-1:0]         new_thread_id,
    output logic                                   running_valid,
    output logic [$clog2(MAX_THREADS)-1:0]         running_thread,
    output logic                                   switched,
    output logic [$clog2(MAX_THREADS):0]           signaled_count,
    input  logic                                   cfg_we,
    input  logic                                   cfg_index,
    input  logic [prrs_pkg::CFG_W-1:0]             cfg_wdata
);

    localparam int IW = $clog2(MAX_THREADS);
    localparam int EW = $bits(prrs_pkg::entry_t);

    prrs_pkg::sched_state_t state_reg, state_next;

    logic [15:0]                  quantum_reg, quantum_next;
    logic [prrs_pkg::DEVCNT_W-1:0] devcnt_reg, devcnt_next;
    logic [15:0]                  stamp_reg, stamp_next;
    logic [IW:0]                  next_id_reg, next_id_next;
    logic                         cur_valid_reg, cur_valid_next;
    logic [IW-1:0]                cur_id_reg, cur_id_next;
    logic [2:0]                   cur_prio_reg, cur_prio_next;
    logic [15:0]                  cur_elapsed_reg, cur_elapsed_next;
    logic [2:0]                   op_reg, op_next;
    logic [2:0]                   prio_reg, prio_next;
    logic [7:0]                   dev_reg, dev_next;
    logic [1:0]                   wr_place_reg, wr_place_next;
    logic [1:0]                   new_place_reg, new_place_next;
    logic [IW-1:0]                new_id_reg, new_id_next;
    logic                         preempt_reg, preempt_next;
    logic                         tick_chk_reg, tick_chk_next;
    logic [1:0]                   res_status_reg, res_status_next;
    logic                         res_newid_ok_reg, res_newid_ok_next;
    logic [IW:0]                  sig_cnt_reg, sig_cnt_next;
    logic                         old_valid_reg, old_valid_next;
    logic [IW-1:0]                old_id_reg, old_id_next;
    logic [IW:0]                  issue_reg, issue_next;
    logic                         pend_valid_reg, pend_valid_next;
    logic [IW-1:0]                pend_id_reg, pend_id_next;
    logic                         found_reg, found_next;
    logic [IW-1:0]                best_id_reg, best_id_next;
    prrs_pkg::entry_t             best_reg, best_next;

    logic                         out_valid_reg, out_valid_next;
    logic [1:0]                   out_status_reg, out_status_next;
    logic [IW-1:0]                out_newid_reg, out_newid_next;
    logic                         out_rvalid_reg, out_rvalid_next;
    logic [IW-1:0]                out_rthread_reg, out_rthread_next;
    logic                         out_switched_reg, out_switched_next;
    logic [IW:0]                  out_sig_reg, out_sig_next;

    logic                         ram_we;
    logic [IW-1:0]                ram_waddr;
    prrs_pkg::entry_t             ram_wentry;
    logic [EW-1:0]                ram_rdata;
    prrs_pkg::entry_t             rd_entry;

    logic                         accept;
    logic                         dev_ok;
    logic                         prio_bad;
    logic                         table_full;
    logic [15:0]                  elapsed_inc;
    logic                         quantum_hit;
    logic                         match;
    logic                         goes_before;
    logic [15:0]                  stamp_diff;
    logic                         scan_done;
    logic                         result_load;

    prrs_ram #(
        .WIDTH(EW),
        .DEPTH(MAX_THREADS)
    ) u_thread_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wentry),
        .raddr(issue_reg[IW-1:0]),
        .rdata(ram_rdata)
    );

    assign rd_entry    = prrs_pkg::entry_t'(ram_rdata);
    assign accept      = in_valid && !in_stall;
    assign dev_ok      = ({1'b0, io_device} < devcnt_reg)
                         && ({1'b0, io_device} < prrs_pkg::DEVCNT_W'(MAX_DEVICES));
    assign prio_bad    = priority_req > 3'(MAX_PRIORITY);
    assign table_full  = next_id_reg >= (IW+1)'(MAX_THREADS);
    assign elapsed_inc = cur_elapsed_reg + 16'd1;
    assign quantum_hit = elapsed_inc == quantum_reg;
    assign match       = (op_reg == prrs_pkg::ACT_SIGNAL)
                         ? (rd_entry.place == prrs_pkg::PLACE_WAIT && rd_entry.device == dev_reg)
                         : (rd_entry.place == prrs_pkg::PLACE_READY);
    assign stamp_diff  = rd_entry.stamp - best_reg.stamp;
    assign goes_before = (rd_entry.prio > best_reg.prio)
                         || (rd_entry.prio == best_reg.prio && stamp_diff[15]);
    assign scan_done   = (issue_reg == next_id_reg) && !pend_valid_reg;
    assign result_load = (state_reg == prrs_pkg::S_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            prrs_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = prrs_pkg::S_DONE;
                    case (action)
                        prrs_pkg::ACT_FORK:
                        begin
                            if (!prio_bad && !table_full)
                            begin
                                if (cur_valid_reg && priority_req > cur_prio_reg)
                                begin
                                    state_next = prrs_pkg::S_WR_CUR;
                                end
                                else
                                begin
                                    state_next = prrs_pkg::S_WR_NEW;
                                end
                            end
                        end
                        prrs_pkg::ACT_WAIT:
                        begin
                            if (dev_ok && cur_valid_reg)
                            begin
                                state_next = prrs_pkg::S_WR_CUR;
                            end
                        end
                        prrs_pkg::ACT_SIGNAL:
                        begin
                            if (dev_ok)
                            begin
                                state_next = prrs_pkg::S_SCAN;
                            end
                        end
                        prrs_pkg::ACT_TICK:
                        begin
                            if (cur_valid_reg)
                            begin
                                state_next = quantum_hit ? prrs_pkg::S_WR_CUR : prrs_pkg::S_SCAN;
                            end
                        end
                        prrs_pkg::ACT_FINISH:
                        begin
                            if (cur_valid_reg)
                            begin
                                state_next = prrs_pkg::S_WR_CUR;
                            end
                        end
                        default:
                        begin
                            state_next = prrs_pkg::S_DONE;
                        end
                    endcase
                end
            end
            prrs_pkg::S_WR_CUR:
            begin
                if (op_reg == prrs_pkg::ACT_FORK)
                begin
                    state_next = prrs_pkg::S_WR_NEW;
                end
                else if (preempt_reg)
                begin
                    state_next = prrs_pkg::S_WR_HEAD;
                end
                else
                begin
                    state_next = prrs_pkg::S_SCAN;
                end
            end
            prrs_pkg::S_WR_NEW:
            begin
                state_next = prrs_pkg::S_DONE;
            end
            prrs_pkg::S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = prrs_pkg::S_SCAN_END;
                end
            end
            prrs_pkg::S_SCAN_END:
            begin
                if (op_reg == prrs_pkg::ACT_SIGNAL)
                begin
                    state_next = found_reg ? prrs_pkg::S_SIG_WR : prrs_pkg::S_DONE;
                end
                else if (tick_chk_reg)
                begin
                    state_next = (found_reg && best_reg.prio > cur_prio_reg)
                                 ? prrs_pkg::S_WR_CUR : prrs_pkg::S_DONE;
                end
                else
                begin
                    state_next = found_reg ? prrs_pkg::S_WR_HEAD : prrs_pkg::S_DONE;
                end
            end
            prrs_pkg::S_SIG_WR:
            begin
                state_next = prrs_pkg::S_SCAN;
            end
            prrs_pkg::S_WR_HEAD:
            begin
                state_next = prrs_pkg::S_DONE;
            end
            prrs_pkg::S_DONE:
            begin
                if (result_load)
                begin
                    state_next = prrs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = prrs_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall   = state_reg != prrs_pkg::S_IDLE;
        ram_we     = 1'b0;
        ram_waddr  = cur_id_reg;
        ram_wentry = '{prio: cur_prio_reg, elapsed: cur_elapsed_reg, device: dev_reg,
                       stamp: stamp_reg, place: wr_place_reg};
        unique case (state_reg)
            prrs_pkg::S_WR_CUR:
            begin
                ram_we = 1'b1;
            end
            prrs_pkg::S_WR_NEW:
            begin
                ram_we     = 1'b1;
                ram_waddr  = new_id_reg;
                ram_wentry = '{prio: prio_reg, elapsed: '0, device: '0,
                               stamp: stamp_reg, place: new_place_reg};
            end
            prrs_pkg::S_SIG_WR:
            begin
                ram_we           = 1'b1;
                ram_waddr        = best_id_reg;
                ram_wentry       = best_reg;
                ram_wentry.stamp = stamp_reg;
                ram_wentry.place = prrs_pkg::PLACE_READY;
            end
            prrs_pkg::S_WR_HEAD:
            begin
                ram_we           = 1'b1;
                ram_waddr        = best_id_reg;
                ram_wentry       = best_reg;
                ram_wentry.place = prrs_pkg::PLACE_RUN;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        quantum_next      = quantum_reg;
        devcnt_next       = devcnt_reg;
        stamp_next        = stamp_reg;
        next_id_next      = next_id_reg;
        cur_valid_next    = cur_valid_reg;
        cur_id_next       = cur_id_reg;
        cur_prio_next     = cur_prio_reg;
        cur_elapsed_next  = cur_elapsed_reg;
        op_next           = op_reg;
        prio_next         = prio_reg;
        dev_next          = dev_reg;
        wr_place_next     = wr_place_reg;
        new_place_next    = new_place_reg;
        new_id_next       = new_id_reg;
        preempt_next      = preempt_reg;
        tick_chk_next     = tick_chk_reg;
        res_status_next   = res_status_reg;
        res_newid_ok_next = res_newid_ok_reg;
        sig_cnt_next      = sig_cnt_reg;
        old_valid_next    = old_valid_reg;
        old_id_next       = old_id_reg;
        issue_next        = issue_reg;
        pend_valid_next   = 1'b0;
        pend_id_next      = pend_id_reg;
        found_next        = found_reg;
        best_id_next      = best_id_reg;
        best_next         = best_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                prrs_pkg::CFG_TIME_QUANTUM:    quantum_next = cfg_wdata[15:0];
                prrs_pkg::CFG_IO_DEVICE_COUNT: devcnt_next  = cfg_wdata[prrs_pkg::DEVCNT_W-1:0];
                default:                       quantum_next = quantum_reg;
            endcase
        end

        if (accept)
        begin
            op_next           = action;
            prio_next         = priority_req;
            dev_next          = io_device;
            preempt_next      = 1'b0;
            tick_chk_next     = 1'b0;
            res_status_next   = prrs_pkg::STATUS_OK;
            res_newid_ok_next = 1'b0;
            sig_cnt_next      = '0;
            old_valid_next    = cur_valid_reg;
            old_id_next       = cur_id_reg;
            wr_place_next     = prrs_pkg::PLACE_READY;
            case (action)
                prrs_pkg::ACT_FORK:
                begin
                    if (prio_bad)
                    begin
                        res_status_next = prrs_pkg::STATUS_BAD_ARG;
                    end
                    else if (table_full)
                    begin
                        res_status_next = prrs_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        res_newid_ok_next = 1'b1;
                        new_id_next       = next_id_reg[IW-1:0];
                        next_id_next      = next_id_reg + (IW+1)'(1);
                        new_place_next    = (!cur_valid_reg || priority_req > cur_prio_reg)
                                            ? prrs_pkg::PLACE_RUN : prrs_pkg::PLACE_READY;
                    end
                end
                prrs_pkg::ACT_WAIT:
                begin
                    wr_place_next = prrs_pkg::PLACE_WAIT;
                    if (!dev_ok)
                    begin
                        res_status_next = prrs_pkg::STATUS_BAD_ARG;
                    end
                    else if (!cur_valid_reg)
                    begin
                        res_status_next = prrs_pkg::STATUS_NO_RUN;
                    end
                end
                prrs_pkg::ACT_SIGNAL:
                begin
                    if (!dev_ok)
                    begin
                        res_status_next = prrs_pkg::STATUS_BAD_ARG;
                    end
                end
                prrs_pkg::ACT_TICK:
                begin
                    if (!cur_valid_reg)
                    begin
                        res_status_next = prrs_pkg::STATUS_NO_RUN;
                    end
                    else
                    begin
                        cur_elapsed_next = quantum_hit ? 16'd0 : elapsed_inc;
                        tick_chk_next    = !quantum_hit;
                    end
                end
                prrs_pkg::ACT_FINISH:
                begin
                    wr_place_next = prrs_pkg::PLACE_FREE;
                    if (!cur_valid_reg)
                    begin
                        res_status_next = prrs_pkg::STATUS_NO_RUN;
                    end
                end
                default:
                begin
                    res_status_next = prrs_pkg::STATUS_BAD_ARG;
                end
            endcase
        end

        case (state_reg)
            prrs_pkg::S_WR_CUR:
            begin
                if (wr_place_reg != prrs_pkg::PLACE_FREE)
                begin
                    stamp_next = stamp_reg + 16'd1;
                end
            end
            prrs_pkg::S_WR_NEW:
            begin
                if (new_place_reg == prrs_pkg::PLACE_RUN)
                begin
                    cur_valid_next   = 1'b1;
                    cur_id_next      = new_id_reg;
                    cur_prio_next    = prio_reg;
                    cur_elapsed_next = 16'd0;
                end
                else
                begin
                    stamp_next = stamp_reg + 16'd1;
                end
            end
            prrs_pkg::S_SCAN:
            begin
                if (issue_reg != next_id_reg)
                begin
                    issue_next      = issue_reg + (IW+1)'(1);
                    pend_valid_next = 1'b1;
                    pend_id_next    = issue_reg[IW-1:0];
                end
                if (pend_valid_reg && match && (!found_reg || goes_before))
                begin
                    found_next   = 1'b1;
                    best_id_next = pend_id_reg;
                    best_next    = rd_entry;
                end
            end
            prrs_pkg::S_SCAN_END:
            begin
                if (op_reg != prrs_pkg::ACT_SIGNAL && !tick_chk_reg && !found_reg)
                begin
                    cur_valid_next = 1'b0;
                    cur_id_next    = '0;
                end
                if (tick_chk_reg && found_reg && best_reg.prio > cur_prio_reg)
                begin
                    preempt_next = 1'b1;
                end
            end
            prrs_pkg::S_SIG_WR:
            begin
                stamp_next   = stamp_reg + 16'd1;
                sig_cnt_next = sig_cnt_reg + (IW+1)'(1);
            end
            prrs_pkg::S_WR_HEAD:
            begin
                cur_valid_next   = 1'b1;
                cur_id_next      = best_id_reg;
                cur_prio_next    = best_reg.prio;
                cur_elapsed_next = best_reg.elapsed;
            end
            default:
            begin
                pend_valid_next = 1'b0;
            end
        endcase

        if (state_next == prrs_pkg::S_SCAN && state_reg != prrs_pkg::S_SCAN)
        begin
            issue_next = '0;
            found_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next    = out_valid_reg && out_stall;
        out_status_next   = out_status_reg;
        out_newid_next    = out_newid_reg;
        out_rvalid_next   = out_rvalid_reg;
        out_rthread_next  = out_rthread_reg;
        out_switched_next = out_switched_reg;
        out_sig_next      = out_sig_reg;
        if (result_load)
        begin
            out_valid_next    = 1'b1;
            out_status_next   = res_status_reg;
            out_newid_next    = res_newid_ok_reg ? new_id_reg : '0;
            out_rvalid_next   = cur_valid_reg;
            out_rthread_next  = cur_valid_reg ? cur_id_reg : '0;
            out_switched_next = (old_valid_reg != cur_valid_reg)
                                || (cur_valid_reg && old_id_reg != cur_id_reg);
            out_sig_next      = sig_cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= prrs_pkg::S_IDLE;
            quantum_reg    <= 16'd1;
            devcnt_reg     <= '0;
            stamp_reg      <= '0;
            next_id_reg    <= '0;
            cur_valid_reg  <= 1'b0;
            cur_id_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            quantum_reg    <= quantum_next;
            devcnt_reg     <= devcnt_next;
            stamp_reg      <= stamp_next;
            next_id_reg    <= next_id_next;
            cur_valid_reg  <= cur_valid_next;
            cur_id_reg     <= cur_id_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_prio_reg     <= cur_prio_next;
        cur_elapsed_reg  <= cur_elapsed_next;
        op_reg           <= op_next;
        prio_reg         <= prio_next;
        dev_reg          <= dev_next;
        wr_place_reg     <= wr_place_next;
        new_place_reg    <= new_place_next;
        new_id_reg       <= new_id_next;
        preempt_reg      <= preempt_next;
        tick_chk_reg     <= tick_chk_next;
        res_status_reg   <= res_status_next;
        res_newid_ok_reg <= res_newid_ok_next;
        sig_cnt_reg      <= sig_cnt_next;
        old_valid_reg    <= old_valid_next;
        old_id_reg       <= old_id_next;
        issue_reg        <= issue_next;
        pend_id_reg      <= pend_id_next;
        found_reg        <= found_next;
        best_id_reg      <= best_id_next;
        best_reg         <= best_next;
        out_status_reg   <= out_status_next;
        out_newid_reg    <= out_newid_next;
        out_rvalid_reg   <= out_rvalid_next;
        out_rthread_reg  <= out_rthread_next;
        out_switched_reg <= out_switched_next;
        out_sig_reg      <= out_sig_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign new_thread_id  = out_newid_reg;
    assign running_valid  = out_rvalid_reg;
    assign running_thread = out_rthread_reg;
    assign switched       = out_switched_reg;
    assign signaled_count = out_sig_reg;

endmodule

// ===== rtl/prrs_checker.sv =====
`timescale 1ns / 1ps

module prrs_checker #(
    parameter int MAX_THREADS = 64
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [1:0]                     status,
    input logic [$clog2(MAX_THREADS)-1:0] new_thread_id,
    input logic                           running_valid,
    input logic [$clog2(MAX_THREADS)-1:0] running_thread,
    input logic                           switched,
    input logic [$clog2(MAX_THREADS):0]   signaled_count
);

    // A rejected beat leaves the schedule as it was.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != prrs_pkg::STATUS_OK |-> !switched && signaled_count == '0
            && new_thread_id == '0)
    else $error("rejected beat reports a change");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !running_valid |-> running_thread == '0)
    else $error("idle processor reports a thread");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == prrs_pkg::STATUS_NO_RUN |-> !running_valid)
    else $error("no running thread reported while one runs");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(running_thread)
            && $stable(signaled_count))
    else $error("stalled result beat changed");

endmodule

bind priority_round_robin_scheduler_core prrs_checker #(.MAX_THREADS(MAX_THREADS)) u_prrs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .new_thread_id (new_thread_id),
    .running_valid (running_valid),
    .running_thread(running_thread),
    .switched      (switched),
    .signaled_count(signaled_count)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int NTHR = 64;
    localparam int MAXPRI = 5;
    localparam int CYCLE_LIMIT = 10_000_000;

    typedef struct packed {
        logic [2:0] act;
        logic [2:0] prio;
        logic [7:0] dev;
    } sched_cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] new_id;
        logic       run_valid;
        logic [5:0] run_thread;
        logic       switched;
        logic [6:0] signaled;
    } sched_resp_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  action;
    logic [2:0]  priority_req;
    logic [7:0]  io_device;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [5:0]  new_thread_id;
    logic        running_valid;
    logic [5:0]  running_thread;
    logic        switched;
    logic [6:0]  signaled_count;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_wdata;

    priority_round_robin_scheduler_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .priority_req(priority_req), .io_device(io_device),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .new_thread_id(new_thread_id),
        .running_valid(running_valid), .running_thread(running_thread),
        .switched(switched), .signaled_count(signaled_count),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    sched_cmd_t  pending_cmds[$];
    sched_resp_t expected_resps[$];
    int          fail_count = 0;
    int          cycle_count = 0;

    // Shadow copy of the scheduler state.
    logic [15:0] quantum;
    logic [8:0]  dev_count;
    logic [2:0]  thr_prio[NTHR];
    logic [15:0] thr_elapsed[NTHR];
    logic [1:0]  thr_place[NTHR];
    logic [7:0]  thr_dev[NTHR];
    logic [15:0] thr_stamp[NTHR];
    logic [15:0] stamp_ctr;
    logic [6:0]  id_ctr;
    logic        run_v;
    logic [5:0]  run_id;

    function automatic bit ahead_of(int a, int b);
        logic [15:0] d;
        if (thr_prio[a] != thr_prio[b])
            return thr_prio[a] > thr_prio[b];
        if (thr_stamp[a] == thr_stamp[b])
            return a < b;
        d = thr_stamp[a] - thr_stamp[b];
        return d[15];
    endfunction

    function automatic void enqueue(int id, logic [1:0] where);
        thr_place[id] = where;
        thr_stamp[id] = stamp_ctr;
        stamp_ctr = stamp_ctr + 16'd1;
    endfunction

    function automatic int ready_head();
        int best;
        best = -1;
        for (int i = 0; i < NTHR; i++)
            if (thr_place[i] == prrs_pkg::PLACE_READY && (best < 0 || ahead_of(i, best)))
                best = i;
        return best;
    endfunction

    function automatic void run_next();
        int h;
        h = ready_head();
        if (h < 0)
        begin
            run_v = 1'b0;
            run_id = '0;
        end
        else
        begin
            run_v = 1'b1;
            run_id = h[5:0];
            thr_place[h] = prrs_pkg::PLACE_RUN;
        end
    endfunction

    function automatic sched_resp_t schedule_beat(sched_cmd_t c);
        sched_resp_t r;
        logic        was_v;
        logic [5:0]  was_id;
        logic [5:0]  cur;
        logic [5:0]  id;
        bit          dev_ok;
        int          best;
        int          h;
        r = '0;
        was_v = run_v;
        was_id = run_id;
        cur = run_id;
        dev_ok = {1'b0, c.dev} < dev_count;
        case (c.act)
            prrs_pkg::ACT_FORK:
            begin
                if (c.prio > MAXPRI)
                    r.status = prrs_pkg::STATUS_BAD_ARG;
                else if (id_ctr >= NTHR)
                    r.status = prrs_pkg::STATUS_FULL;
                else
                begin
                    id = id_ctr[5:0];
                    id_ctr = id_ctr + 7'd1;
                    r.new_id = id;
                    thr_prio[id] = c.prio;
                    thr_elapsed[id] = '0;
                    if (!run_v)
                    begin
                        thr_place[id] = prrs_pkg::PLACE_RUN;
                        run_v = 1'b1;
                        run_id = id;
                    end
                    else if (c.prio > thr_prio[cur])
                    begin
                        enqueue(cur, prrs_pkg::PLACE_READY);
                        thr_place[id] = prrs_pkg::PLACE_RUN;
                        run_id = id;
                    end
                    else
                        enqueue(id, prrs_pkg::PLACE_READY);
                end
            end
            prrs_pkg::ACT_WAIT:
            begin
                if (!dev_ok)
                    r.status = prrs_pkg::STATUS_BAD_ARG;
                else if (!run_v)
                    r.status = prrs_pkg::STATUS_NO_RUN;
                else
                begin
                    thr_dev[cur] = c.dev;
                    enqueue(cur, prrs_pkg::PLACE_WAIT);
                    run_next();
                end
            end
            prrs_pkg::ACT_SIGNAL:
            begin
                if (!dev_ok)
                    r.status = prrs_pkg::STATUS_BAD_ARG;
                else
                    forever
                    begin
                        best = -1;
                        for (int i = 0; i < NTHR; i++)
                            if (thr_place[i] == prrs_pkg::PLACE_WAIT && thr_dev[i] == c.dev
                                && (best < 0 || ahead_of(i, best)))
                                best = i;
                        if (best < 0)
                            break;
                        enqueue(best, prrs_pkg::PLACE_READY);
                        r.signaled = r.signaled + 7'd1;
                    end
            end
            prrs_pkg::ACT_TICK:
            begin
                if (!run_v)
                    r.status = prrs_pkg::STATUS_NO_RUN;
                else
                begin
                    thr_elapsed[cur] = thr_elapsed[cur] + 16'd1;
                    if (thr_elapsed[cur] == quantum)
                    begin
                        thr_elapsed[cur] = '0;
                        enqueue(cur, prrs_pkg::PLACE_READY);
                        run_next();
                    end
                    else
                    begin
                        h = ready_head();
                        if (h >= 0 && thr_prio[h] > thr_prio[cur])
                        begin
                            enqueue(cur, prrs_pkg::PLACE_READY);
                            run_next();
                        end
                    end
                end
            end
            prrs_pkg::ACT_FINISH:
            begin
                if (!run_v)
                    r.status = prrs_pkg::STATUS_NO_RUN;
                else
                begin
                    thr_place[cur] = prrs_pkg::PLACE_FREE;
                    run_next();
                end
            end
            default: r.status = prrs_pkg::STATUS_BAD_ARG;
        endcase
        r.run_valid = run_v;
        r.run_thread = run_v ? run_id : '0;
        r.switched = (was_v != run_v) || (run_v && was_id != run_id);
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Driver: bursts of beats separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        bit accepted;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action <= '0;
            priority_req <= '0;
            io_device <= '0;
        end
        else
        begin
            accepted = in_valid && !in_stall;
            if (accepted)
            begin
                expected_resps.push_back(schedule_beat(pending_cmds[0]));
                void'(pending_cmds.pop_front());
            end
            if (!(in_valid && !accepted))
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    in_valid <= 1'b1;
                    action <= pending_cmds[0].act;
                    priority_req <= pending_cmds[0].prio;
                    io_device <= pending_cmds[0].dev;
                    if (burst_left > 0)
                        burst_left = burst_left - 1;
                    else
                    begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compares each accepted result and drives the stall pattern.
    int resp_count = 0;
    int hold_left = 0;
    bit held = 0;
    int stall_mode = 0;

    always @(posedge clk or negedge rst_n)
    begin
        sched_resp_t e;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                resp_count = resp_count + 1;
                if (expected_resps.size() == 0)
                begin
                    $error("result beat with no expectation waiting");
                    fail_count++;
                end
                else
                begin
                    e = expected_resps.pop_front();
                    if (status !== e.status)
                    begin
                        $error("status: expected %0d, actual %0d", e.status, status);
                        fail_count++;
                    end
                    if (new_thread_id !== e.new_id)
                    begin
                        $error("new_thread_id: expected %0d, actual %0d",
                               e.new_id, new_thread_id);
                        fail_count++;
                    end
                    if (running_valid !== e.run_valid)
                    begin
                        $error("running_valid: expected %0d, actual %0d",
                               e.run_valid, running_valid);
                        fail_count++;
                    end
                    if (running_thread !== e.run_thread)
                    begin
                        $error("running_thread: expected %0d, actual %0d",
                               e.run_thread, running_thread);
                        fail_count++;
                    end
                    if (switched !== e.switched)
                    begin
                        $error("switched: expected %0d, actual %0d", e.switched, switched);
                        fail_count++;
                    end
                    if (signaled_count !== e.signaled)
                    begin
                        $error("signaled_count: expected %0d, actual %0d",
                               e.signaled, signaled_count);
                        fail_count++;
                    end
                end
                if (resp_count == 150 && !held)
                begin
                    held = 1;
                    hold_left = 3000;
                end
            end
            if (cycle_count % 200 == 0)
                stall_mode = $urandom_range(0, 2);
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (stall_mode == 0)
                out_stall <= 1'b0;
            else if (stall_mode == 1)
                out_stall <= ($urandom_range(0, 3) == 0);
            else
                out_stall <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic add_cmd(logic [2:0] a, logic [2:0] p, logic [7:0] d);
        sched_cmd_t c;
        c.act = a;
        c.prio = p;
        c.dev = d;
        pending_cmds.push_back(c);
    endtask

    task automatic drain();
        while (pending_cmds.size() > 0 || expected_resps.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == prrs_pkg::CFG_TIME_QUANTUM)
            quantum = val;
        else
            dev_count = val[8:0];
        @(posedge clk);
    endtask

    task automatic random_phase(int n, int ndev);
        int r;
        logic [7:0] d;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            d = ($urandom_range(0, 9) == 0 || ndev == 0) ? 8'($urandom)
                                                         : 8'($urandom_range(0, ndev - 1));
            if (r < 18)
                add_cmd(prrs_pkg::ACT_FORK, ($urandom_range(0, 9) == 0)
                        ? 3'($urandom) : 3'($urandom_range(0, MAXPRI)), d);
            else if (r < 33)
                add_cmd(prrs_pkg::ACT_WAIT, 3'($urandom), d);
            else if (r < 48)
                add_cmd(prrs_pkg::ACT_SIGNAL, 3'($urandom), d);
            else if (r < 85)
                add_cmd(prrs_pkg::ACT_TICK, 3'($urandom), d);
            else if (r < 93)
                add_cmd(prrs_pkg::ACT_FINISH, 3'($urandom), d);
            else
                add_cmd(3'($urandom_range(5, 7)), 3'($urandom), 8'($urandom));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_wdata = '0;
        quantum = 16'd1;
        dev_count = '0;
        stamp_ctr = '0;
        id_ctr = '0;
        run_v = 1'b0;
        run_id = '0;
        for (int i = 0; i < NTHR; i++)
        begin
            thr_prio[i] = '0;
            thr_elapsed[i] = '0;
            thr_place[i] = prrs_pkg::PLACE_FREE;
            thr_dev[i] = '0;
            thr_stamp[i] = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_cmd(prrs_pkg::ACT_TICK, 3'd0, 8'd0);
        add_cmd(prrs_pkg::ACT_FINISH, 3'd0, 8'd0);
        add_cmd(prrs_pkg::ACT_WAIT, 3'd0, 8'd0);
        add_cmd(prrs_pkg::ACT_SIGNAL, 3'd7, 8'd0);
        add_cmd(3'd5, 3'd0, 8'd0);
        add_cmd(3'd7, 3'd7, 8'hFF);
        add_cmd(prrs_pkg::ACT_FORK, 3'd7, 8'd0);
        add_cmd(prrs_pkg::ACT_FORK, 3'd6, 8'd0);
        add_cmd(prrs_pkg::ACT_FORK, 3'd0, 8'd0);
        add_cmd(prrs_pkg::ACT_FORK, 3'd5, 8'd0);
        add_cmd(prrs_pkg::ACT_TICK, 3'd0, 8'd0);
        add_cmd(prrs_pkg::ACT_TICK, 3'd0, 8'd0);
        drain();
        write_reg(prrs_pkg::CFG_TIME_QUANTUM, 16'd3);
        write_reg(prrs_pkg::CFG_IO_DEVICE_COUNT, 16'd256);
        add_cmd(prrs_pkg::ACT_FORK, 3'd5, 8'd0);
        add_cmd(prrs_pkg::ACT_FORK, 3'd2, 8'd0);
        add_cmd(prrs_pkg::ACT_WAIT, 3'd0, 8'hFF);
        add_cmd(prrs_pkg::ACT_WAIT, 3'd0, 8'hFF);
        add_cmd(prrs_pkg::ACT_SIGNAL, 3'd0, 8'd17);
        add_cmd(prrs_pkg::ACT_SIGNAL, 3'd0, 8'hFF);
        add_cmd(prrs_pkg::ACT_TICK, 3'd0, 8'd0);
        add_cmd(prrs_pkg::ACT_TICK, 3'd0, 8'd0);
        add_cmd(prrs_pkg::ACT_TICK, 3'd0, 8'd0);
        add_cmd(prrs_pkg::ACT_FINISH, 3'd0, 8'd0);
        add_cmd(prrs_pkg::ACT_FINISH, 3'd0, 8'd0);
        drain();

        write_reg(prrs_pkg::CFG_TIME_QUANTUM, 16'hFFFF);
        write_reg(prrs_pkg::CFG_IO_DEVICE_COUNT, 16'd4);
        random_phase(200, 4);
        drain();
        write_reg(prrs_pkg::CFG_TIME_QUANTUM, 16'd2);
        write_reg(prrs_pkg::CFG_IO_DEVICE_COUNT, 16'd1);
        random_phase(200, 1);
        drain();
        write_reg(prrs_pkg::CFG_TIME_QUANTUM, 16'd0);
        write_reg(prrs_pkg::CFG_IO_DEVICE_COUNT, 16'd256);
        random_phase(200, 256);
        drain();
        write_reg(prrs_pkg::CFG_TIME_QUANTUM, 16'd1);
        write_reg(prrs_pkg::CFG_IO_DEVICE_COUNT, 16'd8);
        random_phase(200, 8);
        drain();
        write_reg(prrs_pkg::CFG_IO_DEVICE_COUNT, 16'd0);
        random_phase(20, 0);
        drain();

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/prrs_pkg.sv
rtl/prrs_ram.sv
rtl/priority_round_robin_scheduler_core.sv
rtl/prrs_checker.sv
verif/tb_top.sv
